// ===== sv/sacl_pkg.sv =====
package sacl_pkg;

  localparam int DEF_MAX_LINES  = 1024;
  localparam int DEF_MAX_WAYS   = 8;
  localparam int DEF_ADDR_WIDTH = 32;

  localparam int CNT_W     = 28;
  localparam int SET_OUT_W = 10;
  localparam int WAY_OUT_W = 3;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;
  localparam int FLD_W     = 4;
  localparam int WCNT_W    = 5;

  localparam logic [CNT_W-1:0] STAMP_LIMIT = 28'hfffffff;

  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_SET_BITS    = 2'd1;
  localparam logic [1:0] REG_WAYS        = 2'd2;

  typedef struct packed {
    logic [FLD_W-1:0]  offset_bits;
    logic [FLD_W-1:0]  set_bits;
    logic [WCNT_W-1:0] ways;
  } cfg_eff_t;

endpackage

// ===== sv/sacl_if.sv =====
interface sacl_in_if #(
  parameter int AW = sacl_pkg::DEF_ADDR_WIDTH
);
  logic          valid;
  logic          ready;
  logic [AW-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sacl_out_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic [sacl_pkg::CNT_W-1:0]        access_number;
  logic [sacl_pkg::SET_OUT_W-1:0]    set_index;
  logic [sacl_pkg::WAY_OUT_W-1:0]    way_used;
  logic [sacl_pkg::CNT_W-1:0]        hit_count;
  logic [sacl_pkg::CNT_W-1:0]        miss_count;

  modport source (output valid, output hit, output access_number, output set_index,
                  output way_used, output hit_count, output miss_count, input ready);
  modport sink   (input valid, input hit, input access_number, input set_index,
                  input way_used, input hit_count, input miss_count, output ready);
endinterface

// ===== sv/sacl_ram.sv =====
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/sacl_cfg.sv =====
module sacl_cfg #(
  parameter int MAX_LINES = sacl_pkg::DEF_MAX_LINES,
  parameter int MAX_WAYS  = sacl_pkg::DEF_MAX_WAYS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sacl_pkg::CFG_AW-1:0]   paddr,
  input  logic [sacl_pkg::CFG_DW-1:0]   pwdata,
  output logic [sacl_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output sacl_pkg::cfg_eff_t            eff,
  output logic                          clr
);
  import sacl_pkg::*;

  logic [FLD_W-1:0] offset_bits_r, offset_bits_nxt;
  logic [FLD_W-1:0] set_bits_r, set_bits_nxt;
  logic [FLD_W-1:0] ways_r, ways_nxt;
  cfg_eff_t         eff_r, eff_nxt;
  logic             wr;
  logic [1:0]       idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign eff    = eff_r;

  always_comb begin
    offset_bits_nxt = offset_bits_r;
    set_bits_nxt    = set_bits_r;
    ways_nxt        = ways_r;
    clr             = 1'b0;
    prdata          = '0;
    unique case (idx)
      REG_OFFSET_BITS: begin
        prdata = CFG_DW'(offset_bits_r);
        if (wr) begin
          offset_bits_nxt = pwdata[FLD_W-1:0];
          clr             = 1'b1;
        end
      end
      REG_SET_BITS: begin
        prdata = CFG_DW'(set_bits_r);
        if (wr) begin
          set_bits_nxt = pwdata[FLD_W-1:0];
          clr          = 1'b1;
        end
      end
      REG_WAYS: begin
        prdata = CFG_DW'(ways_r);
        if (wr) begin
          ways_nxt = pwdata[FLD_W-1:0];
          clr      = 1'b1;
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_comb begin
    logic [WCNT_W-1:0] w;
    w = WCNT_W'(ways_r);
    if (w == '0) begin
      w = WCNT_W'(1);
    end
    if (int'(w) > MAX_WAYS) begin
      w = WCNT_W'(MAX_WAYS);
    end
    if (int'(w) > MAX_LINES) begin
      w = WCNT_W'(MAX_LINES);
    end
    eff_nxt.offset_bits = offset_bits_r;
    eff_nxt.ways        = w;
    eff_nxt.set_bits    = '0;
    for (int k = 1; k < 16; k++) begin
      if (k <= int'(set_bits_r) && ((32'd1 << k) * 32'(w)) <= 32'(MAX_LINES)) begin
        eff_nxt.set_bits = FLD_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= FLD_W'(4);
      set_bits_r    <= FLD_W'(6);
      ways_r        <= FLD_W'(1);
      eff_r         <= '0;
    end else begin
      offset_bits_r <= offset_bits_nxt;
      set_bits_r    <= set_bits_nxt;
      ways_r        <= ways_nxt;
      eff_r         <= eff_nxt;
    end
  end

endmodule

// ===== sv/sacl_sel.sv =====
module sacl_sel #(
  parameter int MAX_WAYS   = sacl_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH = sacl_pkg::DEF_ADDR_WIDTH
) (
  input  logic [ADDR_WIDTH+sacl_pkg::CNT_W:0]     ent [MAX_WAYS],
  input  logic [ADDR_WIDTH-1:0]                   tag,
  input  logic [sacl_pkg::WCNT_W-1:0]             ways,
  output logic                                    hit,
  output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] way
);
  import sacl_pkg::*;

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ENT_W = 1 + ADDR_WIDTH + CNT_W;

  always_comb begin
    logic             found;
    logic             found_valid;
    logic [WAY_W-1:0] way_f;
    logic [WAY_W-1:0] way_l;
    logic [CNT_W-1:0] best;
    found       = 1'b0;
    found_valid = 1'b0;
    way_f       = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (WCNT_W'(i) < ways &&
          (!ent[i][ENT_W-1] || ent[i][ENT_W-2:CNT_W] == tag)) begin
        found       = 1'b1;
        found_valid = ent[i][ENT_W-1];
        way_f       = WAY_W'(i);
      end
    end
    best  = ent[0][CNT_W-1:0];
    way_l = '0;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (WCNT_W'(i) < ways && ent[i][CNT_W-1:0] < best) begin
        best  = ent[i][CNT_W-1:0];
        way_l = WAY_W'(i);
      end
    end
    hit = found && found_valid;
    way = found ? way_f : way_l;
  end

endmodule

// ===== sv/set_assoc_cache_lru_tags_core.sv =====
// Channel   Direction  Payload                                      Handshake
// in_req    in         address                                      valid/ready
// out_rsp   out        hit, access_number, set_index, way_used,     valid/ready
//                      hit_count, miss_count
// APB       in/out     offset_bits, set_bits, ways                  psel/penable
//
// Each request first reads all ways of the set from the way-banked tag memory, then
// compares, picks the victim and writes the entry back.
// After reset and after every write to a mapped register the memory is swept over all
// MAX_LINES entries to clear the valid bits; no request is accepted meanwhile.
// A result waiting in the output register stalls only the write-back of the next request.
module set_assoc_cache_lru_tags_core #(
  parameter int MAX_LINES  = sacl_pkg::DEF_MAX_LINES,
  parameter int MAX_WAYS   = sacl_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH = sacl_pkg::DEF_ADDR_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sacl_pkg::CFG_AW-1:0]   paddr,
  input  logic [sacl_pkg::CFG_DW-1:0]   pwdata,
  output logic [sacl_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  sacl_in_if.sink                       in_req,
  sacl_out_if.source                    out_rsp
);
  import sacl_pkg::*;

  localparam int SET_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ENT_W = 1 + ADDR_WIDTH + CNT_W;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_LOOK = 2'd2;

  cfg_eff_t eff;
  logic     cfg_clr;

  logic [1:0]            state_r, state_nxt;
  logic [SET_W-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [SET_W-1:0]      set_r, set_nxt;
  logic [ADDR_WIDTH-1:0] tag_r, tag_nxt;
  logic [CNT_W-1:0]      acc_r, acc_nxt;
  logic [CNT_W-1:0]      hits_r, hits_nxt;
  logic [CNT_W-1:0]      miss_r, miss_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_hit_r, out_hit_nxt;
  logic [CNT_W-1:0]      out_acc_r, out_acc_nxt;
  logic [SET_W-1:0]      out_set_r, out_set_nxt;
  logic [WAY_W-1:0]      out_way_r, out_way_nxt;

  logic                  accept;
  logic                  done;
  logic [ADDR_WIDTH-1:0] sh_addr;
  logic [SET_W-1:0]      in_set;
  logic [ADDR_WIDTH-1:0] in_tag;
  logic [ENT_W-1:0]      rd_ent [MAX_WAYS];
  logic                  sel_hit;
  logic [WAY_W-1:0]      sel_way;
  logic                  ram_we_all;
  logic [SET_W-1:0]      ram_waddr;
  logic [ENT_W-1:0]      ram_wdata;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v < STAMP_LIMIT) ? v + CNT_W'(1) : STAMP_LIMIT;
  endfunction

  sacl_cfg #(
    .MAX_LINES (MAX_LINES),
    .MAX_WAYS  (MAX_WAYS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eff     (eff),
    .clr     (cfg_clr)
  );

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign done         = (state_r == ST_LOOK) && (!out_valid_r || out_rsp.ready);

  assign sh_addr = in_req.address >> eff.offset_bits;
  assign in_set  = sh_addr[SET_W-1:0] & ~({SET_W{1'b1}} << eff.set_bits);
  assign in_tag  = in_req.address >> (WCNT_W'(eff.offset_bits) + WCNT_W'(eff.set_bits));

  assign ram_we_all = (state_r == ST_CLR);
  assign ram_waddr  = (state_r == ST_CLR) ? clr_cnt_r : set_r;
  assign ram_wdata  = (state_r == ST_CLR) ? '0 : {1'b1, tag_r, acc_r};

  for (genvar b = 0; b < MAX_WAYS; b++) begin : g_bank
    sacl_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_LINES)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we_all || (done && sel_way == WAY_W'(b))),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (in_set),
      .rdata (rd_ent[b])
    );
  end

  sacl_sel #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_sel (
    .ent  (rd_ent),
    .tag  (tag_r),
    .ways (eff.ways),
    .hit  (sel_hit),
    .way  (sel_way)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    set_nxt       = set_r;
    tag_nxt       = tag_r;
    acc_nxt       = acc_r;
    hits_nxt      = hits_r;
    miss_nxt      = miss_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_hit_nxt   = out_hit_r;
    out_acc_nxt   = out_acc_r;
    out_set_nxt   = out_set_r;
    out_way_nxt   = out_way_r;
    unique case (state_r)
      ST_CLR: begin
        clr_cnt_nxt = clr_cnt_r + SET_W'(1);
        if (clr_cnt_r == SET_W'(MAX_LINES - 1)) begin
          state_nxt   = ST_IDLE;
          clr_cnt_nxt = '0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          set_nxt   = in_set;
          tag_nxt   = in_tag;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (done) begin
          if (sel_hit) begin
            hits_nxt = sat_inc(hits_r);
          end else begin
            miss_nxt = sat_inc(miss_r);
          end
          acc_nxt       = sat_inc(acc_r);
          out_valid_nxt = 1'b1;
          out_hit_nxt   = sel_hit;
          out_acc_nxt   = acc_r;
          out_set_nxt   = set_r;
          out_way_nxt   = sel_way;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
    if (cfg_clr) begin
      state_nxt   = ST_CLR;
      clr_cnt_nxt = '0;
      acc_nxt     = CNT_W'(1);
      hits_nxt    = '0;
      miss_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      acc_r       <= CNT_W'(1);
      hits_r      <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      acc_r       <= acc_nxt;
      hits_r      <= hits_nxt;
      miss_r      <= miss_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    set_r     <= set_nxt;
    tag_r     <= tag_nxt;
    out_hit_r <= out_hit_nxt;
    out_acc_r <= out_acc_nxt;
    out_set_r <= out_set_nxt;
    out_way_r <= out_way_nxt;
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.hit           = out_hit_r;
  assign out_rsp.access_number = out_acc_r;
  assign out_rsp.set_index     = SET_OUT_W'(out_set_r);
  assign out_rsp.way_used      = WAY_OUT_W'(out_way_r);
  assign out_rsp.hit_count     = hits_r;
  assign out_rsp.miss_count    = miss_r;

endmodule

// ===== test/tb_set_assoc_cache_lru_tags_core.sv =====
`timescale 1ns / 100ps

module tb_set_assoc_cache_lru_tags_core;
  import sacl_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                 hit;
    logic [CNT_W-1:0]     access_number;
    logic [SET_OUT_W-1:0] set_index;
    logic [WAY_OUT_W-1:0] way_used;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  sacl_in_if in_ch ();
  sacl_out_if out_ch ();

  set_assoc_cache_lru_tags_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_req(in_ch),
    .out_rsp(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the cache tag state.
  logic [3:0]       cfg_offset;
  logic [3:0]       cfg_set_bits;
  logic [3:0]       cfg_ways;
  logic             line_valid [DEF_MAX_LINES];
  logic [31:0]      line_tag [DEF_MAX_LINES];
  logic [CNT_W-1:0] line_stamp [DEF_MAX_LINES];
  logic [CNT_W-1:0] access_ctr;
  logic [CNT_W-1:0] hits_total;
  logic [CNT_W-1:0] misses_total;

  logic [31:0]    pending_addresses[$];
  lookup_result_t predicted_lookups[$];

  logic        no_idle;
  logic [31:0] tag_base;
  logic [31:0] set_base;
  int          send_gap;
  int          recv_stall;
  int          bad_results = 0;
  int          cycle_count = 0;

  function automatic logic [CNT_W-1:0] sat_next(logic [CNT_W-1:0] v);
    return (v < STAMP_LIMIT) ? v + CNT_W'(1) : STAMP_LIMIT;
  endfunction

  function automatic void clear_lines();
    foreach (line_valid[i]) line_valid[i] = 1'b0;
    access_ctr = CNT_W'(1);
    hits_total = '0;
    misses_total = '0;
  endfunction

  function automatic void geometry(output int w, output int s);
    w = int'(cfg_ways);
    if (w == 0) w = 1;
    if (w > DEF_MAX_WAYS) w = DEF_MAX_WAYS;
    s = int'(cfg_set_bits);
    while (s > 0 && ((1 << s) * w) > DEF_MAX_LINES) s--;
  endfunction

  function automatic lookup_result_t cache_access(logic [31:0] addr);
    int w;
    int s;
    int base;
    int way;
    int i;
    logic [31:0] set_sel;
    logic [31:0] tag;
    logic [CNT_W-1:0] stamp;
    logic [CNT_W-1:0] oldest;
    logic hit;
    logic done;
    lookup_result_t r;
    geometry(w, s);
    set_sel = (addr >> cfg_offset) & ((32'd1 << s) - 32'd1);
    tag = addr >> (cfg_offset + s);
    base = set_sel * w;
    stamp = access_ctr;
    hit = 1'b0;
    done = 1'b0;
    way = 0;
    for (i = 0; i < w && !done; i++) begin
      if (!line_valid[base + i]) begin
        line_valid[base + i] = 1'b1;
        line_tag[base + i] = tag;
        line_stamp[base + i] = stamp;
        way = i;
        done = 1'b1;
      end else if (line_tag[base + i] == tag) begin
        line_stamp[base + i] = stamp;
        way = i;
        hit = 1'b1;
        done = 1'b1;
      end
    end
    if (!done) begin
      oldest = line_stamp[base];
      way = 0;
      for (i = 1; i < w; i++) begin
        if (line_stamp[base + i] < oldest) begin
          oldest = line_stamp[base + i];
          way = i;
        end
      end
      line_tag[base + way] = tag;
      line_stamp[base + way] = stamp;
    end
    if (hit) hits_total = sat_next(hits_total);
    else misses_total = sat_next(misses_total);
    r.hit = hit;
    r.access_number = stamp;
    r.set_index = set_sel[SET_OUT_W-1:0];
    r.way_used = way[WAY_OUT_W-1:0];
    r.hit_count = hits_total;
    r.miss_count = misses_total;
    access_ctr = sat_next(access_ctr);
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Most addresses come from a few tags in a few sets so that hits and LRU
  // replacements are frequent; the rest are spread widely or fully random.
  function automatic logic [31:0] pick_address();
    int w;
    int s;
    int k;
    logic [63:0] tag;
    logic [63:0] set_sel;
    logic [63:0] a;
    geometry(w, s);
    k = $urandom_range(0, 19);
    if (k == 0) return $urandom();
    tag = 64'(tag_base) + 64'($urandom_range(0, w + 1));
    set_sel = (k < 5) ? 64'($urandom()) : 64'(set_base) + 64'($urandom_range(0, 2));
    a = (tag << (cfg_offset + s)) | ((set_sel & ((64'd1 << s) - 64'd1)) << cfg_offset)
        | (64'($urandom()) & ((64'd1 << cfg_offset) - 64'd1));
    return a[31:0];
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [3:0] value);
    logic [31:0] data;
    data = $urandom();
    data[3:0] = value;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_OFFSET_BITS: begin
        cfg_offset = value;
        clear_lines();
      end
      REG_SET_BITS: begin
        cfg_set_bits = value;
        clear_lines();
      end
      REG_WAYS: begin
        cfg_ways = value;
        clear_lines();
      end
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_addresses.size() != 0 || in_ch.valid || predicted_lookups.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_geometry(input logic [3:0] off, input logic [3:0] sb,
                              input logic [3:0] nw, input logic quiet);
    reg_write(REG_OFFSET_BITS, off);
    reg_write(REG_SET_BITS, sb);
    reg_write(REG_WAYS, nw);
    tag_base = $urandom();
    set_base = $urandom();
    no_idle = quiet;
  endtask

  task automatic run_random(input int n);
    repeat (n) pending_addresses.push_back(pick_address());
    wait_drained();
  endtask

  task automatic push_lru_probe(input int tag);
    pending_addresses.push_back((tag << 10) | (5 << 4));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.address <= '0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predicted_lookups.push_back(cache_access(in_ch.address));
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_addresses.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.address <= pending_addresses.pop_front();
          send_gap = idle_len();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.hit = out_ch.hit;
        got.access_number = out_ch.access_number;
        got.set_index = out_ch.set_index;
        got.way_used = out_ch.way_used;
        got.hit_count = out_ch.hit_count;
        got.miss_count = out_ch.miss_count;
        if (predicted_lookups.size() == 0) begin
          if (bad_results < 10)
            $display("unexpected result: hit=%0d num=%0d set=%0d way=%0d hits=%0d misses=%0d",
                     got.hit, got.access_number, got.set_index, got.way_used,
                     got.hit_count, got.miss_count);
          bad_results++;
        end else begin
          want = predicted_lookups.pop_front();
          if (got !== want) begin
            if (bad_results < 10) begin
              $display("mismatch: expected hit=%0d num=%0d set=%0d way=%0d hits=%0d misses=%0d",
                       want.hit, want.access_number, want.set_index, want.way_used,
                       want.hit_count, want.miss_count);
              $display("          actual   hit=%0d num=%0d set=%0d way=%0d hits=%0d misses=%0d",
                       got.hit, got.access_number, got.set_index, got.way_used,
                       got.hit_count, got.miss_count);
            end
            bad_results++;
          end
        end
        recv_stall = idle_len();
      end else if (recv_stall == 0 && !no_idle && $urandom_range(0, 15) == 0) begin
        recv_stall = idle_len();
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg_offset = 4'd4;
    cfg_set_bits = 4'd6;
    cfg_ways = 4'd1;
    clear_lines();
    no_idle = 1'b0;
    tag_base = $urandom();
    set_base = $urandom();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Default geometry: direct mapped, 64 sets of 16-byte blocks.
    pending_addresses.push_back(32'h0000_0000);
    pending_addresses.push_back(32'h0000_0000);
    pending_addresses.push_back(32'hffff_ffff);
    pending_addresses.push_back(32'hffff_ffff);
    pending_addresses.push_back(32'h0000_000f);
    pending_addresses.push_back(32'h0000_0400);
    pending_addresses.push_back(32'h0000_0000);
    pending_addresses.push_back(32'h0000_03f0);
    pending_addresses.push_back(32'h8000_0000);
    pending_addresses.push_back(32'h7fff_ffff);
    run_random(150);

    // Four ways: fill one set, refresh a way, then evict the oldest twice.
    set_geometry(4'd4, 4'd6, 4'd4, 1'b1);
    push_lru_probe(1);
    push_lru_probe(2);
    push_lru_probe(3);
    push_lru_probe(4);
    push_lru_probe(1);
    push_lru_probe(5);
    push_lru_probe(2);
    push_lru_probe(1);
    run_random(200);

    set_geometry(4'd0, 4'd0, 4'd8, 1'b0);
    run_random(200);
    set_geometry(4'd12, 4'd10, 4'd1, 1'b0);
    run_random(200);
    set_geometry(4'd15, 4'd15, 4'd15, 1'b1);
    run_random(200);
    set_geometry(4'd0, 4'd2, 4'd0, 1'b0);
    run_random(150);

    // A write outside the register map must leave contents and counters alone.
    reg_write(REG_UNUSED, 4'd3);
    run_random(150);

    set_geometry(4'd7, 4'd9, 4'd2, 1'b0);
    run_random(200);
    set_geometry(4'd2, 4'd10, 4'd8, 1'b0);
    run_random(200);

    repeat (10) @(posedge clk);
    if (bad_results == 0 && predicted_lookups.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
